>>> rtl/core/sipb_pkg.sv
`timescale 1ns / 1ps
// Package for the servo instruction packet builder: command codes, protocol
// constants, scaling constants and the packet descriptor. No dependencies.
package sipb_pkg;

  typedef enum logic [3:0] {
    ACT_PING      = 4'd0,
    ACT_REBOOT    = 4'd1,
    ACT_TORQUE    = 4'd2,
    ACT_LED       = 4'd3,
    ACT_GOAL      = 4'd4,
    ACT_SPEED     = 4'd5,
    ACT_READ_POS  = 4'd6,
    ACT_READ_SPD  = 4'd7,
    ACT_READ_MOVE = 4'd8
  } action_e;

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] BCAST_ID    = 8'hFE;
  localparam logic [7:0] INS_PING    = 8'h01;
  localparam logic [7:0] INS_READ    = 8'h02;
  localparam logic [7:0] INS_WRITE   = 8'h03;
  localparam logic [7:0] INS_REBOOT  = 8'h08;
  localparam logic [7:0] REG_TORQUE  = 8'h18;
  localparam logic [7:0] REG_LED     = 8'h19;
  localparam logic [7:0] REG_GOAL    = 8'h1E;
  localparam logic [7:0] REG_SPEED   = 8'h20;
  localparam logic [7:0] REG_POS_NOW = 8'h24;
  localparam logic [7:0] REG_SPD_NOW = 8'h26;
  localparam logic [7:0] REG_MOVING  = 8'h2E;

  localparam logic [3:0] REPLY_STD   = 4'd6;
  localparam logic [3:0] REPLY_WORD  = 4'd8;
  localparam logic [3:0] REPLY_BYTE  = 4'd7;
  localparam logic [3:0] REPLY_NONE  = 4'd0;

  // angle*1023/300 == angle*341/100, pct*1023/100: both become x/100
  localparam int unsigned XW         = 17;           // x <= 102300
  localparam logic [15:0] ANGLE_MAX  = 16'd300;
  localparam logic [15:0] PCT_MAX    = 16'd100;
  localparam logic [XW-1:0] GOAL_MUL = 17'd341;
  localparam logic [XW-1:0] SPD_MUL  = 17'd1023;
  // floor(x/100) = (x * ceil(2^24/100)) >> 24, exact for x < 199728
  localparam int unsigned RECIP_SH   = 24;
  localparam logic [17:0] RECIP_100  = 18'd167773;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] ins;
    logic [7:0] par0;
    logic [7:0] par1;
    logic [7:0] par2;
    logic [1:0] npar;
    logic [7:0] chk;
    logic [3:0] reply;
  } pkt_desc_t;

endpackage

>>> rtl/core/servo_instruction_packet_builder.sv
`timescale 1ns / 1ps
// Top level of the servo bus instruction packet builder.
// Depends on sipb_pkg, sipb_front, sipb_queue and sipb_back.
//
//  channel  | direction | handshake      | payload
//  ---------+-----------+----------------+----------------------------------------
//  command  | in        | push / full    | action_i, servo_id_i, command_value_i
//  bytes    | out       | pop / empty    | tx_byte_o, last_byte_o, reply_length_o
//
// A command is held in the front-end register (clamp and constant multiply
// before it, reciprocal divide and checksum after it) until the queue has
// room, and enters the queue from there.
// The back end emits one byte per cycle while a descriptor is queued and pop keeps
// up: 6 bytes for ping and reboot, 8 for torque, LED and reads, 9 for goal and
// speed; that serialiser sets the sustained command rate. With an empty pipe the
// first byte passes from the front-end register through the queue into the result register.
// Reset is asynchronous, active low, and empties every stage; no clearing pass.
// Either side may stall freely: a full queue holds the front stage, and the
// result register only advances when empty is high or pop is taken.
// Unknown actions (9 to 15) are accepted and produce no bytes.
module servo_instruction_packet_builder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  action_i,
  input  logic [7:0]  servo_id_i,
  input  logic [15:0] command_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  tx_byte_o,
  output logic        last_byte_o,
  output logic [3:0]  reply_length_o
);
  import sipb_pkg::*;

  logic      fr_valid;
  pkt_desc_t fr_desc;
  logic      q_full;
  logic      q_empty;
  logic      q_rd;
  pkt_desc_t q_desc;

  // front end: request acceptance and classification
  sipb_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .action_i        (action_i),
    .servo_id_i      (servo_id_i),
    .command_value_i (command_value_i),
    .desc_valid_o    (fr_valid),
    .desc_o          (fr_desc),
    .desc_full_i     (q_full)
  );

  // decouples the two halves so each can stall on its own
  sipb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fr_valid),
    .wdata_i (fr_desc),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_desc),
    .empty_o (q_empty)
  );

  // back end: byte serialiser with its own result register
  sipb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_empty_i   (q_empty),
    .desc_i         (q_desc),
    .desc_rd_o      (q_rd),
    .empty_o        (empty),
    .pop_i          (pop),
    .tx_byte_o      (tx_byte_o),
    .last_byte_o    (last_byte_o),
    .reply_length_o (reply_length_o)
  );

endmodule

>>> rtl/core/sipb_front.sv
`timescale 1ns / 1ps
// Front end: accepts commands, clamps and scales the value, builds a packet
// descriptor with checksum. Depends on sipb_pkg.
module sipb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [3:0]          action_i,
  input  logic [7:0]          servo_id_i,
  input  logic [15:0]         command_value_i,
  output logic                desc_valid_o,
  output sipb_pkg::pkt_desc_t desc_o,
  input  logic                desc_full_i
);
  import sipb_pkg::*;

  logic            s1_valid_q, s1_valid_d;
  action_e         s1_act_q;
  logic [7:0]      s1_id_q;
  logic            s1_bit_q;
  logic [XW-1:0]   s1_x_q;
  logic            s1_load;
  logic            act_ok;
  logic [15:0]     clamped;
  logic [XW-1:0]   x_d;
  logic [34:0]     prod;
  logic [9:0]      pos;
  pkt_desc_t       d;

  assign full_o  = s1_valid_q && desc_full_i;
  assign s1_load = push_i && !full_o;
  assign act_ok  = (action_i <= ACT_READ_MOVE);

  // stage 1: clamp and constant multiply
  always_comb begin
    x_d     = '0;
    clamped = '0;
    if (action_e'(action_i) == ACT_GOAL) begin
      clamped = (command_value_i > ANGLE_MAX) ? ANGLE_MAX : command_value_i;
      x_d     = XW'(clamped) * GOAL_MUL;
    end else begin
      clamped = (command_value_i > PCT_MAX) ? PCT_MAX : command_value_i;
      x_d     = XW'(clamped) * SPD_MUL;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = act_ok;   // unknown commands vanish here
    end else if (s1_valid_q && !desc_full_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_act_q <= action_e'(action_i);
      s1_id_q  <= servo_id_i;
      s1_bit_q <= command_value_i[0];
      s1_x_q   <= x_d;
    end
  end

  // stage 2: divide by 100 through the reciprocal, then the descriptor
  assign prod = 35'(s1_x_q) * 35'(RECIP_100);
  assign pos  = prod[RECIP_SH+9:RECIP_SH];

  always_comb begin
    d       = '0;
    d.id    = s1_id_q;
    d.ins   = INS_WRITE;
    d.npar  = 2'd2;
    d.reply = REPLY_STD;
    unique case (s1_act_q)
      ACT_PING: begin
        d.ins  = INS_PING;
        d.npar = 2'd0;
      end
      ACT_REBOOT: begin
        d.ins  = INS_REBOOT;
        d.npar = 2'd0;
      end
      ACT_TORQUE: begin
        d.par0 = REG_TORQUE;
        d.par1 = {7'd0, s1_bit_q};
        if (s1_id_q == BCAST_ID) begin
          d.reply = REPLY_NONE;
        end
      end
      ACT_LED: begin
        d.par0 = REG_LED;
        d.par1 = {7'd0, s1_bit_q};
      end
      ACT_GOAL: begin
        d.par0 = REG_GOAL;
        d.par1 = pos[7:0];
        d.par2 = {6'd0, pos[9:8]};
        d.npar = 2'd3;
      end
      ACT_SPEED: begin
        d.par0 = REG_SPEED;
        d.par1 = pos[7:0];
        d.par2 = {6'd0, pos[9:8]};
        d.npar = 2'd3;
      end
      ACT_READ_POS: begin
        d.ins   = INS_READ;
        d.par0  = REG_POS_NOW;
        d.par1  = 8'd2;
        d.reply = REPLY_WORD;
      end
      ACT_READ_SPD: begin
        d.ins   = INS_READ;
        d.par0  = REG_SPD_NOW;
        d.par1  = 8'd2;
        d.reply = REPLY_WORD;
      end
      ACT_READ_MOVE: begin
        d.ins   = INS_READ;
        d.par0  = REG_MOVING;
        d.par1  = 8'd1;
        d.reply = REPLY_BYTE;
      end
      default: begin
        d.npar = 2'd0;
      end
    endcase
    d.len = 8'(d.npar) + 8'd2;
    // unused parameter slots are zero, so they drop out of the sum
    d.chk = ~(d.id + d.len + d.ins + d.par0 + d.par1 + d.par2);
  end

  assign desc_valid_o = s1_valid_q;
  assign desc_o       = d;

endmodule

>>> rtl/core/sipb_queue.sv
`timescale 1ns / 1ps
// Small descriptor queue between front and back end.
// Depends on sipb_pkg.
module sipb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  sipb_pkg::pkt_desc_t wdata_i,
  output logic                full_o,
  input  logic                rd_i,
  output sipb_pkg::pkt_desc_t rdata_o,
  output logic                empty_o
);
  import sipb_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pkt_desc_t       mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/core/sipb_back.sv
`timescale 1ns / 1ps
// Back end: walks one descriptor byte by byte into the result register.
// Depends on sipb_pkg.
module sipb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                desc_empty_i,
  input  sipb_pkg::pkt_desc_t desc_i,
  output logic                desc_rd_o,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [7:0]          tx_byte_o,
  output logic                last_byte_o,
  output logic [3:0]          reply_length_o
);
  import sipb_pkg::*;

  logic [3:0] idx_q;
  logic [3:0] last_idx;
  logic       out_valid_q;
  logic       load;
  logic       is_last;
  logic [7:0] byte_sel;

  assign load     = !out_valid_q || pop_i;
  assign last_idx = 4'(desc_i.npar) + 4'd5;
  assign is_last  = (idx_q == last_idx);
  assign desc_rd_o = load && !desc_empty_i && is_last;

  always_comb begin
    byte_sel = HDR_BYTE;
    if (is_last) begin
      byte_sel = desc_i.chk;
    end else begin
      case (idx_q)
        4'd2:    byte_sel = desc_i.id;
        4'd3:    byte_sel = desc_i.len;
        4'd4:    byte_sel = desc_i.ins;
        4'd5:    byte_sel = desc_i.par0;
        4'd6:    byte_sel = desc_i.par1;
        4'd7:    byte_sel = desc_i.par2;
        default: byte_sel = HDR_BYTE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= !desc_empty_i;
      if (!desc_empty_i) begin
        idx_q <= is_last ? 4'd0 : idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !desc_empty_i) begin
      tx_byte_o      <= byte_sel;
      last_byte_o    <= is_last;
      reply_length_o <= desc_i.reply;
    end
  end

  assign empty_o = !out_valid_q;

endmodule

>>> rtl/core/sipb_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the packet builder, bound to the top level.
// Depends only on the top level's ports.
module sipb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  tx_byte_o,
  input logic        last_byte_o,
  input logic [3:0]  reply_length_o
);

  // position within the current packet, saturating at 7
  logic [2:0] pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (pop && !empty) begin
      if (last_byte_o) begin
        pos_q <= '0;
      end else if (pos_q != 3'd7) begin
        pos_q <= pos_q + 3'd1;
      end
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(tx_byte_o) && $stable(last_byte_o)
                          && $stable(reply_length_o)))
    else $error("result changed while stalled");

  a_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pos_q < 3'd2) |-> (tx_byte_o == 8'hFF && !last_byte_o))
    else $error("packet does not open with two header bytes");

  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_byte_o) |-> (pos_q >= 3'd5))
    else $error("packet ended too early");

  a_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (reply_length_o == 4'd0 || reply_length_o == 4'd6 ||
                reply_length_o == 4'd7 || reply_length_o == 4'd8))
    else $error("bad reply length");

endmodule

bind servo_instruction_packet_builder sipb_checker u_sipb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .tx_byte_o      (tx_byte_o),
  .last_byte_o    (last_byte_o),
  .reply_length_o (reply_length_o)
);
